>>> rtl/wsts_pkg.sv
// package for the work stealing task scheduler
// holds sizes, status codes, register indexes and sequencer states
package wsts_pkg;
   localparam int NumThreads  = 8;
   localparam int RunqDepth   = 256;
   localparam int GlobalDepth = 1024;
   localparam int TidW  = $clog2(NumThreads);
   localparam int LPtrW = $clog2(RunqDepth);
   localparam int LCntW = $clog2(RunqDepth + 1);
   localparam int LAddrW = TidW + LPtrW;
   localparam int GPtrW = $clog2(GlobalDepth);
   localparam int GCntW = $clog2(GlobalDepth + 1);
   localparam int NThrW = $clog2(NumThreads + 1);

   localparam logic [2:0] ST_LOCAL   = 3'd0;
   localparam logic [2:0] ST_GLOBAL  = 3'd1;
   localparam logic [2:0] ST_DROPPED = 3'd2;
   localparam logic [2:0] ST_FOUND   = 3'd3;
   localparam logic [2:0] ST_NONE    = 3'd4;

   localparam logic [1:0] REG_ACTIVE = 2'd0;
   localparam logic [1:0] REG_BATCH  = 2'd1;
   localparam logic [1:0] REG_PERIOD = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_SCHED, S_F_START, S_PULL_RD, S_PULL_WR, S_POP_RD, S_POP_WAIT,
      S_STEAL_SCAN, S_STEAL_RD, S_STEAL_WR, S_DONE
   } state_type;

   // which pull is running
   typedef enum logic [1:0] {P_FIRST, P_SECOND, P_LAST} pull_type;
endpackage

>>> rtl/work_stealing_task_scheduler_unit.sv
// work stealing task scheduler top level: sequencer, local and global stores
// depends on wsts_pkg
// schedule runs S_SCHED then S_DONE; find runs S_F_START, S_POP_RD and S_POP_WAIT for a pop
// of the own queue, S_PULL_RD/WR to pull, S_STEAL_SCAN and S_STEAL_RD/WR to steal
// throughput: one item at a time, busy high until the result cycle
// reset: synchronous, clears heads, counts and ticks, sets registers to defaults; stores not cleared
module work_stealing_task_scheduler_unit import wsts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [15:0] req_task_id,
   input  logic [2:0]  req_thread_id,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_task_out,
   output logic [2:0]  rsp_queue_used,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [15:0] lmem [NumThreads*RunqDepth];
   logic [15:0] gmem [GlobalDepth];
   logic [15:0] lrd, grd;
   logic        lwe, gwe;
   logic [LAddrW-1:0] lwa, lra;
   logic [GPtrW-1:0]  gwa, gra;
   logic [15:0] lwd, gwd;

   always_ff @(posedge clock) begin
      if (lwe) lmem[lwa] <= lwd;
      lrd <= lmem[lra];
      if (gwe) gmem[gwa] <= gwd;
      grd <= gmem[gra];
   end

   logic [3:0] act_ff; logic [7:0] batch_ff, period_ff;
   logic [LPtrW-1:0] head_ff [NumThreads];
   logic [LCntW-1:0] cnt_ff [NumThreads];
   logic [7:0] tick_ff [NumThreads];
   logic [GPtrW-1:0] ghead_ff; logic [GCntW-1:0] gcnt_ff;
   logic [TidW-1:0] disp_ff;
   state_type st_ff, st_in;
   pull_type pk_ff;
   logic [TidW-1:0] tid_ff, vic_ff;
   logic [NThrW-1:0] scan_ff;
   logic [7:0] moved_ff;
   logic [LCntW-1:0] take_ff, j_ff;
   logic [2:0] ostat_ff; logic [15:0] otask_ff; logic [2:0] oq_ff; logic ov_ff;

   logic [NThrW-1:0] n;
   always_comb begin
      if (act_ff == 4'd0) n = NThrW'(1);
      else if (32'(act_ff) > NumThreads) n = NThrW'(NumThreads);
      else n = NThrW'(act_ff);
   end

   function automatic logic [TidW-1:0] nxt(input logic [TidW-1:0] a,
                                           input logic [NThrW-1:0] m);
      logic [NThrW:0] s;
      s = {1'b0, NThrW'(a)} + (NThrW+1)'(1);
      if (s >= {1'b0, m}) s = '0;
      return s[TidW-1:0];
   endfunction

   // stale dispatch index reduced by compare and subtract, quotient fits 3 bits
   function automatic logic [TidW-1:0] wrap_thr(input logic [TidW-1:0] a,
                                                input logic [NThrW-1:0] m);
      logic [NThrW+1:0] r, d;
      r = (NThrW+2)'(a);
      for (int k = 2; k >= 0; k--) begin
         d = (NThrW+2)'(m) << k;
         if (r >= d) r = r - d;
      end
      return r[TidW-1:0];
   endfunction

   logic wr_en;
   assign wr_en = psel & penable & pwrite;
   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[3:2])
         REG_ACTIVE: prdata = 32'(act_ff);
         REG_BATCH:  prdata = 32'(batch_ff);
         REG_PERIOD: prdata = 32'(period_ff);
         default:    prdata = '0;
      endcase
   end

   assign busy = (st_ff != S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_status = ostat_ff;
   assign rsp_task_out = otask_ff;
   assign rsp_queue_used = oq_ff;

   logic [TidW-1:0] tgt, tgt2;
   always_comb begin
      tgt = wrap_thr(disp_ff, n);
      tgt2 = nxt(tgt, n);
   end

   logic [LPtrW-1:0] th_head; logic [LCntW-1:0] th_cnt;
   assign th_head = head_ff[tid_ff];
   assign th_cnt = cnt_ff[tid_ff];
   logic [LPtrW-1:0] vhead; logic [LCntW-1:0] vcnt;
   assign vhead = head_ff[vic_ff];
   assign vcnt = cnt_ff[vic_ff];
   logic can_pull, tid_ok, gfirst;
   assign can_pull = (moved_ff < batch_ff) && (gcnt_ff != '0)
                     && (th_cnt < LCntW'(RunqDepth));
   assign tid_ok = (NThrW'(tid_ff) < n);
   assign gfirst = (tick_ff[tid_ff] == '0);
   logic [8:0] per_lim;
   assign per_lim = (period_ff == '0) ? 9'd1 : {1'b0, period_ff};

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE:       if (start) st_in = req_mode ? S_F_START : S_SCHED;
         S_SCHED:      st_in = S_DONE;
         S_F_START: begin
            if (!tid_ok) st_in = S_DONE;
            else if (gfirst) st_in = S_PULL_RD;
            else if (th_cnt != '0) st_in = S_POP_RD;
            else st_in = S_PULL_RD;
         end
         S_PULL_RD: begin
            if (can_pull) st_in = S_PULL_WR;
            else if (moved_ff != '0) st_in = S_POP_RD;
            else if (pk_ff == P_FIRST)
               st_in = (th_cnt != '0) ? S_POP_RD : S_STEAL_SCAN;
            else if (pk_ff == P_SECOND) st_in = S_STEAL_SCAN;
            else st_in = S_DONE;
         end
         S_PULL_WR:    st_in = S_PULL_RD;
         S_POP_RD:     st_in = S_POP_WAIT;
         S_POP_WAIT:   st_in = S_DONE;
         S_STEAL_SCAN: begin
            if (scan_ff >= n) st_in = S_PULL_RD;
            else if (vcnt == '0) st_in = S_STEAL_SCAN;
            else st_in = S_STEAL_RD;
         end
         S_STEAL_RD:   st_in = S_STEAL_WR;
         S_STEAL_WR:   st_in = ((j_ff + LCntW'(1)) >= take_ff) ? S_DONE : S_STEAL_RD;
         S_DONE:       st_in = S_IDLE;
         default:      st_in = S_IDLE;
      endcase
   end

   always_comb begin
      lwe = 1'b0; gwe = 1'b0;
      lwa = {tid_ff, th_head + LPtrW'(th_cnt)}; lwd = grd;
      lra = {tid_ff, th_head};
      gwa = ghead_ff + GPtrW'(gcnt_ff); gwd = req_task_id;
      gra = ghead_ff;
      if (st_ff == S_STEAL_RD) lra = {vic_ff, vhead};
      if (st_ff == S_PULL_WR) lwe = 1'b1;
      if (st_ff == S_STEAL_WR && j_ff != '0) begin
         lwe = 1'b1; lwd = lrd;
      end
      if (st_ff == S_IDLE && start && !req_mode) begin
         lwd = req_task_id;
         if (cnt_ff[tgt] < LCntW'(RunqDepth)) begin
            lwe = 1'b1; lwa = {tgt, head_ff[tgt] + LPtrW'(cnt_ff[tgt])};
         end else if (cnt_ff[tgt2] < LCntW'(RunqDepth)) begin
            lwe = 1'b1; lwa = {tgt2, head_ff[tgt2] + LPtrW'(cnt_ff[tgt2])};
         end else if (gcnt_ff < GCntW'(GlobalDepth)) gwe = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; act_ff <= 4'd8; batch_ff <= 8'd10; period_ff <= 8'd61;
         ghead_ff <= '0; gcnt_ff <= '0; disp_ff <= '0; ov_ff <= 1'b0;
         pk_ff <= P_FIRST; tid_ff <= '0; vic_ff <= '0; scan_ff <= '0;
         moved_ff <= '0; take_ff <= '0; j_ff <= '0;
         ostat_ff <= ST_NONE; otask_ff <= '0; oq_ff <= '0;
         for (int i = 0; i < NumThreads; i++) begin
            head_ff[i] <= '0; cnt_ff[i] <= '0; tick_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         ov_ff <= 1'b0;
         if (wr_en) begin
            unique case (paddr[3:2])
               REG_ACTIVE: act_ff <= pwdata[3:0];
               REG_BATCH:  batch_ff <= pwdata[7:0];
               REG_PERIOD: period_ff <= pwdata[7:0];
               default: ;
            endcase
         end
         unique case (st_ff)
            S_IDLE: if (start) begin
               tid_ff <= TidW'(req_thread_id);
               ostat_ff <= ST_NONE; otask_ff <= '0; oq_ff <= '0;
               moved_ff <= '0;
               if (!req_mode) begin
                  disp_ff <= tgt2;
                  if (cnt_ff[tgt] < LCntW'(RunqDepth)) begin
                     cnt_ff[tgt] <= cnt_ff[tgt] + LCntW'(1);
                     ostat_ff <= ST_LOCAL; oq_ff <= 3'(tgt);
                  end else if (cnt_ff[tgt2] < LCntW'(RunqDepth)) begin
                     cnt_ff[tgt2] <= cnt_ff[tgt2] + LCntW'(1);
                     ostat_ff <= ST_LOCAL; oq_ff <= 3'(tgt2);
                  end else if (gcnt_ff < GCntW'(GlobalDepth)) begin
                     gcnt_ff <= gcnt_ff + GCntW'(1); ostat_ff <= ST_GLOBAL;
                  end else ostat_ff <= ST_DROPPED;
               end
            end
            S_F_START: if (tid_ok) begin
               tick_ff[tid_ff] <= (({1'b0, tick_ff[tid_ff]} + 9'd1) >= per_lim) ? '0 :
                  tick_ff[tid_ff] + 8'd1;
               pk_ff <= gfirst ? P_FIRST : P_SECOND;
               moved_ff <= '0;
            end
            S_PULL_RD: if (!can_pull) begin
               moved_ff <= '0;
               scan_ff <= NThrW'(1);
               vic_ff <= nxt(tid_ff, n);
            end
            S_PULL_WR: begin
               ghead_ff <= ghead_ff + GPtrW'(1); gcnt_ff <= gcnt_ff - GCntW'(1);
               cnt_ff[tid_ff] <= th_cnt + LCntW'(1); moved_ff <= moved_ff + 8'd1;
            end
            S_POP_RD: begin
               head_ff[tid_ff] <= th_head + LPtrW'(1); cnt_ff[tid_ff] <= th_cnt - LCntW'(1);
            end
            S_POP_WAIT: begin ostat_ff <= ST_FOUND; otask_ff <= lrd; end
            S_STEAL_SCAN: begin
               if (scan_ff >= n) begin
                  pk_ff <= P_LAST; moved_ff <= '0;
               end else if (vcnt == '0) begin
                  scan_ff <= scan_ff + NThrW'(1);
                  vic_ff <= nxt(vic_ff, n);
               end else begin
                  take_ff <= (vcnt > LCntW'(1)) ? (vcnt >> 1) : LCntW'(1);
                  j_ff <= '0;
               end
            end
            S_STEAL_RD: begin
               head_ff[vic_ff] <= vhead + LPtrW'(1);
               cnt_ff[vic_ff] <= vcnt - LCntW'(1);
            end
            S_STEAL_WR: begin
               if (j_ff == '0) begin ostat_ff <= ST_FOUND; otask_ff <= lrd; end
               else cnt_ff[tid_ff] <= th_cnt + LCntW'(1);
               j_ff <= j_ff + LCntW'(1);
            end
            S_DONE: ov_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with result");
   a_gcnt: assert property (@(posedge clock) disable iff (reset)
      gcnt_ff <= GCntW'(GlobalDepth)) else $error("global overflow");
endmodule

>>> sim/tb_work_stealing_task_scheduler_unit.sv
// testbench for the work stealing task scheduler: directed table, random phases, fill to drop
// predicts each result with its own copy of the queues (typed table rows use their given values)
// and checks it field by field; depends on wsts_pkg and work_stealing_task_scheduler_unit
module tb_work_stealing_task_scheduler_unit;
   import wsts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 20000;
   localparam int ExpDepth = 16;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] task_out;
      logic [2:0]  queue_used;
   } outcome_type;

   typedef struct {
      logic        mode;
      logic [15:0] task_id;
      logic [2:0]  thread_id;
      bit          typed;
      outcome_type want;
   } stim_row_type;

   logic        clock, reset, start, busy;
   logic        req_mode;
   logic [15:0] req_task_id;
   logic [2:0]  req_thread_id;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_task_out;
   logic [2:0]  rsp_queue_used;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   work_stealing_task_scheduler_unit uut (.*);

   // scheduler copy
   logic [15:0] lq_store [NumThreads*RunqDepth];
   int          lq_head [NumThreads];
   int          lq_count [NumThreads];
   logic [15:0] gq_store [GlobalDepth];
   int          gq_head, gq_count, rr_next;
   int          find_tick [NumThreads];
   int          cfg_threads, cfg_batch, cfg_period;

   outcome_type exp_ring [ExpDepth];
   int          exp_wr, exp_rd;
   int          errors;
   int          idle_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int exp_level();
      return exp_wr - exp_rd;
   endfunction

   function automatic bit lq_push(int q, logic [15:0] t);
      if (lq_count[q] >= RunqDepth) return 0;
      lq_store[q*RunqDepth + (lq_head[q] + lq_count[q]) % RunqDepth] = t;
      lq_count[q]++;
      return 1;
   endfunction

   function automatic bit lq_pop(int q, output logic [15:0] t);
      t = 16'd0;
      if (lq_count[q] == 0) return 0;
      t = lq_store[q*RunqDepth + lq_head[q]];
      lq_head[q] = (lq_head[q] + 1) % RunqDepth;
      lq_count[q]--;
      return 1;
   endfunction

   function automatic bit gq_pull(int q);
      int moved;
      moved = 0;
      while (moved < cfg_batch && gq_count > 0) begin
         if (!lq_push(q, gq_store[gq_head])) break;
         gq_head = (gq_head + 1) % GlobalDepth;
         gq_count--;
         moved++;
      end
      return moved > 0;
   endfunction

   function automatic bit find_task(int tid, output logic [15:0] t);
      int n, per, tk, victim, take;
      bit gfirst;
      logic [15:0] x;
      n = cfg_threads == 0 ? 1 : (cfg_threads > NumThreads ? NumThreads : cfg_threads);
      per = cfg_period == 0 ? 1 : cfg_period;
      t = 16'd0;
      if (tid >= n) return 0;
      tk = find_tick[tid];
      gfirst = (tk == 0);
      find_tick[tid] = (tk + 1 >= per) ? 0 : tk + 1;
      if (gfirst && gq_pull(tid) && lq_pop(tid, t)) return 1;
      if (lq_pop(tid, t)) return 1;
      if (!gfirst && gq_pull(tid) && lq_pop(tid, t)) return 1;
      for (int i = 1; i < n; i++) begin
         victim = (tid + i) % n;
         if (lq_count[victim] == 0) continue;
         take = lq_count[victim] / 2;
         if (take == 0) take = 1;
         for (int j = 0; j < take; j++) begin
            void'(lq_pop(victim, x));
            if (j == 0) t = x;
            else void'(lq_push(tid, x));
         end
         return 1;
      end
      if (gq_pull(tid) && lq_pop(tid, t)) return 1;
      return 0;
   endfunction

   function automatic outcome_type compute_outcome(logic mode, logic [15:0] tid16,
                                                   logic [2:0] tid);
      outcome_type o;
      int n, tgt;
      logic [15:0] f;
      o = '{ST_NONE, 16'd0, 3'd0};
      if (mode == 1'b0) begin
         n = cfg_threads == 0 ? 1 : (cfg_threads > NumThreads ? NumThreads : cfg_threads);
         tgt = rr_next % n;
         rr_next = (tgt + 1) % n;
         if (lq_push(tgt, tid16)) begin
            o.status = ST_LOCAL;
            o.queue_used = tgt[2:0];
         end else begin
            tgt = (tgt + 1) % n;
            if (lq_push(tgt, tid16)) begin
               o.status = ST_LOCAL;
               o.queue_used = tgt[2:0];
            end else if (gq_count >= GlobalDepth) begin
               o.status = ST_DROPPED;
            end else begin
               gq_store[(gq_head + gq_count) % GlobalDepth] = tid16;
               gq_count++;
               o.status = ST_GLOBAL;
            end
         end
      end else if (find_task(tid, f)) begin
         o.status = ST_FOUND;
         o.task_out = f;
      end
      return o;
   endfunction

   // result checker
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (exp_level() == 0) begin
            $display("%0t: result with nothing expected, status %0d", $time, rsp_status);
            errors++;
         end else begin
            e = exp_ring[exp_rd % ExpDepth];
            exp_rd++;
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d got %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_task_out !== e.task_out) begin
               $display("%0t: task_out expected %h got %h", $time, e.task_out, rsp_task_out);
               errors++;
            end
            if (rsp_queue_used !== e.queue_used) begin
               $display("%0t: queue_used expected %0d got %0d", $time, e.queue_used,
                        rsp_queue_used);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(logic mode, logic [15:0] tid16, logic [2:0] tid, bit typed,
                            outcome_type want);
      outcome_type o;
      @(negedge clock);
      start = 1'b1;
      req_mode = mode;
      req_task_id = tid16;
      req_thread_id = tid;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      o = compute_outcome(mode, tid16, tid);
      exp_ring[exp_wr % ExpDepth] = typed ? want : o;
      exp_wr++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (exp_level() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      case (idx)
         REG_ACTIVE: cfg_threads = value & 'hF;
         REG_BATCH:  cfg_batch = value & 'hFF;
         default:    cfg_period = value & 'hFF;
      endcase
   endtask

   task automatic random_phase(int threads, int batch, int period, int count, bit gaps);
      int burst;
      drain_results();
      csr_write(REG_ACTIVE, threads);
      csr_write(REG_BATCH, batch);
      csr_write(REG_PERIOD, period);
      burst = $urandom_range(1, 20);
      for (int k = 0; k < count; k++) begin
         send_item($urandom_range(0, 99) < 55 ? 1'b0 : 1'b1, 16'($urandom),
                   3'($urandom_range(0, 7)), 0, '{default: '0});
         if (gaps && --burst == 0) begin
            burst = $urandom_range(1, 20);
            @(negedge clock);
            start = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
      end
   endtask

   stim_row_type directed [] = '{
      '{1'b1, 16'h0000, 3'd0, 1, '{ST_NONE, 16'h0000, 3'd0}},
      '{1'b0, 16'hFFFF, 3'd0, 1, '{ST_LOCAL, 16'h0000, 3'd0}},
      '{1'b0, 16'h0000, 3'd7, 1, '{ST_LOCAL, 16'h0000, 3'd1}},
      '{1'b1, 16'h0000, 3'd5, 0, '{default: '0}},
      '{1'b0, 16'h8000, 3'd0, 0, '{default: '0}},
      '{1'b0, 16'h7FFF, 3'd0, 0, '{default: '0}},
      '{1'b0, 16'h1234, 3'd0, 0, '{default: '0}},
      '{1'b1, 16'hFFFF, 3'd7, 0, '{default: '0}},
      '{1'b1, 16'h0000, 3'd1, 0, '{default: '0}},
      '{1'b1, 16'h0000, 3'd2, 0, '{default: '0}},
      '{1'b1, 16'h0000, 3'd3, 0, '{default: '0}},
      '{1'b1, 16'h0000, 3'd4, 0, '{default: '0}}
   };

   initial begin
      int guard;
      errors = 0;
      exp_wr = 0;
      exp_rd = 0;
      reset = 1'b1;
      start = 1'b0;
      req_mode = 1'b0;
      req_task_id = '0;
      req_thread_id = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_threads = 8;
      cfg_batch = 10;
      cfg_period = 61;
      gq_head = 0;
      gq_count = 0;
      rr_next = 0;
      for (int i = 0; i < NumThreads; i++) begin
         lq_head[i] = 0;
         lq_count[i] = 0;
         find_tick[i] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_item(directed[i].mode, directed[i].task_id, directed[i].thread_id,
                   directed[i].typed, directed[i].want);

      random_phase(8, 10, 61, 15, 1);
      random_phase(3, 1, 1, 15, 1);
      random_phase(0, 0, 0, 10, 0);
      random_phase(15, 255, 255, 15, 1);
      random_phase(1, 5, 2, 10, 1);
      random_phase(5, 2, 3, 15, 0);
      random_phase(9, 255, 1, 10, 1);

      // one queue only: fill local and global until items are dropped
      drain_results();
      csr_write(REG_ACTIVE, 1);
      csr_write(REG_BATCH, 255);
      csr_write(REG_PERIOD, 4);
      for (int k = 0; k < 1285; k++)
         send_item(1'b0, 16'($urandom), 3'($urandom_range(0, 7)), 0, '{default: '0});
      for (int k = 0; k < 15; k++)
         send_item(1'b1, 16'($urandom), 3'($urandom_range(0, 1)), 0, '{default: '0});
      drain_results();

      guard = 0;
      while (exp_level() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (600) @(posedge clock);
      if (exp_level() != 0) begin
         $display("%0t: %0d results never arrived", $time, exp_level());
         errors++;
      end
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/wsts_pkg.sv
rtl/work_stealing_task_scheduler_unit.sv
sim/tb_work_stealing_task_scheduler_unit.sv
